FILE: hdl/afm_pkg.sv
package afm_pkg;

  // Grid size of the field map.
  localparam int unsigned GRID_R    = 256;
  localparam int unsigned GRID_Z    = 512;
  localparam int unsigned MEM_DEPTH = GRID_R * GRID_Z;
  localparam int unsigned IX_W      = $clog2(GRID_R);
  localparam int unsigned IZ_W      = $clog2(GRID_Z);
  localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);

  // Field widths of the stream items.
  localparam int unsigned POS_W      = 24;
  localparam int unsigned FLD_W      = 24;
  localparam int unsigned OUT_W      = 28;
  localparam int unsigned STEP_W     = 16;
  localparam int unsigned IN_DATA_W  = 3 * POS_W + 2 * FLD_W;
  localparam int unsigned OUT_DATA_W = ((3 * OUT_W + 7) / 8) * 8;

  // Internal datapath widths.
  localparam int unsigned NUM_W  = 28;  // cell index dividends
  localparam int unsigned DD_W   = 62;  // divider dividend
  localparam int unsigned DV_W   = 34;  // divider divisor
  localparam int unsigned CNT_W  = 6;   // divider bit counter
  localparam int unsigned MUL_W  = 34;  // multiplier operands
  localparam int unsigned PROD_W = 58;  // kept product bits
  localparam int unsigned ACC_W  = 58;  // interpolation sums
  localparam int unsigned SQ_W   = 48;  // x*x + y*y
  localparam int unsigned RAD_W  = 24;  // radius
  localparam int unsigned WGT_W  = 2 * STEP_W + 1;

  // Bits processed by the divider for each kind of division.
  localparam logic [CNT_W-1:0] NB_LOAD = CNT_W'(28);
  localparam logic [CNT_W-1:0] NB_CELL = CNT_W'(27);
  localparam logic [CNT_W-1:0] NB_NORM = CNT_W'(61);
  localparam logic [CNT_W-1:0] NB_ROT  = CNT_W'(54);

  localparam int unsigned FIFO_DEPTH = 2;  // power of two
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIAL_STEP,
    REG_RADIAL_START,
    REG_AXIAL_STEP,
    REG_AXIAL_START,
    REG_AXIAL_CENTER
  } cfg_reg_e;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_INSIDE,
    ST_OUTSIDE,
    ST_STORED,
    ST_BAD_INDEX
  } status_e;

  typedef struct packed {
    logic        [STEP_W-1:0] radial_step;
    logic signed [POS_W-1:0]  radial_start;
    logic        [STEP_W-1:0] axial_step;
    logic signed [POS_W-1:0]  axial_start;
    logic signed [POS_W-1:0]  axial_center;
  } cfg_t;

  typedef struct packed {
    cmd_e                    cmd;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [NUM_W-1:0] num_r;  // load only: 2*(r - start) + step
    logic signed [NUM_W-1:0] num_z;  // load: 2*(z - start) + step, query: z offset
    logic signed [FLD_W-1:0] field_r;
    logic signed [FLD_W-1:0] field_z;
  } item_t;

  typedef struct packed {
    logic                   start;
    logic signed [DD_W-1:0] dividend;
    logic        [DV_W-1:0] divisor;
    logic        [CNT_W-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic                   busy;
    logic                   done;
    logic signed [DD_W-1:0] quot;
    logic        [DV_W-1:0] rem;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LD_R, S_LD_Z, S_LD_ST, S_LD_WR,
    S_SQX, S_SQY, S_SQA, S_SQRT, S_QR, S_QZ, S_QCHK,
    S_CW, S_CR, S_CZ, S_CA, S_NM, S_FZ, S_FR, S_BR,
    S_DX, S_FX, S_DY, S_FY, S_DIVW, S_OUT
  } bk_state_e;

  // A step of zero behaves as a step of one.
  function automatic logic [STEP_W-1:0] step_eff(logic [STEP_W-1:0] s);
    return (s == '0) ? STEP_W'(1) : s;
  endfunction

endpackage

FILE: hdl/afm_front.sv
module afm_front (
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // pos_x, pos_y, pos_z, load_field_r, load_field_z
  input  logic [afm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // command
  input  logic [0:0]                         s_axis_tuser,
  input  afm_pkg::cfg_t                      cfg_i,
  input  logic                               fifo_full_i,
  output logic                               push_o,
  output afm_pkg::item_t                     item_o
);
  import afm_pkg::*;

  logic signed [POS_W-1:0] x, y, z;
  logic [STEP_W-1:0]       sr, sz;
  logic signed [NUM_W-1:0] load_r, load_z, query_z;

  assign x  = $signed(s_axis_tdata[POS_W-1:0]);
  assign y  = $signed(s_axis_tdata[2*POS_W-1:POS_W]);
  assign z  = $signed(s_axis_tdata[3*POS_W-1:2*POS_W]);
  assign sr = step_eff(cfg_i.radial_step);
  assign sz = step_eff(cfg_i.axial_step);

  // Load points round to the nearest cell: floor((2*d + step) / (2*step)).
  assign load_r = ((NUM_W'(x) - NUM_W'(cfg_i.radial_start)) <<< 1)
                + NUM_W'($signed({1'b0, sr}));
  assign load_z = ((NUM_W'(z) - NUM_W'(cfg_i.axial_start)) <<< 1)
                + NUM_W'($signed({1'b0, sz}));
  // Queries are relative to the center and truncate to a cell.
  assign query_z = NUM_W'(z) + NUM_W'(cfg_i.axial_center) - NUM_W'(cfg_i.axial_start);

  assign s_axis_tready = !fifo_full_i;
  assign push_o        = s_axis_tvalid && !fifo_full_i;

  always_comb begin
    item_o.cmd     = cmd_e'(s_axis_tuser[0]);
    item_o.pos_x   = x;
    item_o.pos_y   = y;
    item_o.num_r   = (s_axis_tuser[0] == CMD_LOAD) ? load_r : '0;
    item_o.num_z   = (s_axis_tuser[0] == CMD_LOAD) ? load_z : query_z;
    item_o.field_r = $signed(s_axis_tdata[3*POS_W+FLD_W-1:3*POS_W]);
    item_o.field_z = $signed(s_axis_tdata[3*POS_W+2*FLD_W-1:3*POS_W+FLD_W]);
  end

endmodule

FILE: hdl/afm_fifo.sv
module afm_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  afm_pkg::item_t push_item_i,
  input  logic           pop_i,
  output afm_pkg::item_t head_o,
  output logic           empty_o,
  output logic           full_o
);
  import afm_pkg::*;

  item_t                 slot_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_q, rptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = slot_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + FIFO_PTR_W'(1);
      if (do_pop)  rptr_q <= rptr_q + FIFO_PTR_W'(1);
      if (do_push && !do_pop) cnt_q <= cnt_q + FIFO_CNT_W'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wptr_q] <= push_item_i;
  end

endmodule

FILE: hdl/afm_div.sv
module afm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  afm_pkg::div_req_t req_i,
  output afm_pkg::div_rsp_t rsp_o
);
  import afm_pkg::*;

  // Floor division of a signed dividend by a positive divisor, one quotient
  // bit per cycle. A negative n is handled as floor(n/d) = -(~n / d) - 1.
  logic                  busy_q, done_q, neg_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DD_W-1:0]       mag_q, quo_q;
  logic [DV_W-1:0]       dvs_q, rem_q;
  logic [DV_W:0]         trial;
  logic                  fits;

  assign trial = {rem_q, mag_q[cnt_q]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.dividend[DD_W-1];
      mag_q <= req_i.dividend[DD_W-1] ? ~req_i.dividend : req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
      quo_q <= '0;
      cnt_q <= req_i.nbits - CNT_W'(1);
    end else if (busy_q) begin
      rem_q <= fits ? DV_W'(trial - {1'b0, dvs_q}) : trial[DV_W-1:0];
      quo_q <= {quo_q[DD_W-2:0], fits};
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_comb begin
    rsp_o.busy = busy_q;
    rsp_o.done = done_q;
    rsp_o.quot = neg_q ? $signed(~quo_q) : $signed(quo_q);
    rsp_o.rem  = neg_q ? (dvs_q - DV_W'(1) - rem_q) : rem_q;
  end

endmodule

FILE: hdl/afm_back.sv
module afm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  afm_pkg::cfg_t                 cfg_i,
  input  afm_pkg::item_t                head_i,
  input  logic                          empty_i,
  output logic                          pop_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // field_x, field_y, field_z, zero fill
  output logic [afm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // status
  output logic [1:0]                    m_axis_tuser
);
  import afm_pkg::*;

  bk_state_e state_q, state_d, ret_q, ret_d;

  item_t                    item_q;
  logic [SQ_W-1:0]          sq_q, res_q, bit_q, sq_sum;
  logic                     sq_ge;
  logic [RAD_W-1:0]         r_q;
  logic [IX_W-1:0]          ix_q, ixc;
  logic [IZ_W-1:0]          iz_q, izc;
  logic                     ix_ok_q, ok_q;
  logic [STEP_W-1:0]        rr_q, rz_q, sr, sz;
  logic [STEP_W:0]          wr, wz;
  logic [1:0]               k_q;
  logic [WGT_W-1:0]         weight_q, den_q;
  logic signed [ACC_W-1:0]  acc_r_q, acc_z_q;
  logic signed [OUT_W-1:0]  br_q, fx_q, fy_q, fz_q, quot_o;
  status_e                  status_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_full;
  logic [2*FLD_W-1:0]       field_mem_q [MEM_DEPTH];
  logic [2*FLD_W-1:0]       rdata_q;
  logic [ADDR_W-1:0]        mem_addr;
  logic                     mem_we, out_load, q_nonneg, ix_in, iz_in;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;
  logic                     m_valid_q;
  logic [OUT_DATA_W-1:0]    m_data_q;
  logic [1:0]               m_user_q;

  function automatic logic signed [DD_W-1:0] neg20(logic signed [ACC_W-1:0] a);
    logic signed [DD_W-1:0] e;
    e = DD_W'(a);
    return -((e <<< 4) + (e <<< 2));
  endfunction

  afm_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign sr       = step_eff(cfg_i.radial_step);
  assign sz       = step_eff(cfg_i.axial_step);
  assign wr       = k_q[0] ? {1'b0, rr_q} : ({1'b0, sr} - {1'b0, rr_q});
  assign wz       = k_q[1] ? {1'b0, rz_q} : ({1'b0, sz} - {1'b0, rz_q});
  assign ixc      = ix_q + IX_W'(k_q[0]);
  assign izc      = iz_q + IZ_W'(k_q[1]);
  assign mem_addr = ADDR_W'(ADDR_W'(ixc) * ADDR_W'(GRID_Z) + ADDR_W'(izc));
  assign sq_sum   = res_q + bit_q;
  assign sq_ge    = (sq_q >= sq_sum);
  assign mul_full = mul_a * mul_b;
  assign quot_o   = div_rsp.quot[OUT_W-1:0];
  assign q_nonneg = !div_rsp.quot[DD_W-1];
  assign ix_in    = q_nonneg && (div_rsp.quot <
                    DD_W'((item_q.cmd == CMD_LOAD) ? GRID_R : GRID_R - 1));
  assign iz_in    = q_nonneg && (div_rsp.quot <
                    DD_W'((item_q.cmd == CMD_LOAD) ? GRID_Z : GRID_Z - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ret_q     <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      if (out_load) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  always_comb begin
    state_d          = state_q;
    ret_d            = ret_q;
    pop_o            = 1'b0;
    mem_we           = 1'b0;
    out_load         = 1'b0;
    mul_a            = '0;
    mul_b            = '0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    div_req.nbits    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = (head_i.cmd == CMD_QUERY) ? S_SQX : S_LD_R;
        end
      end
      S_LD_R: begin
        div_req = '{1'b1, DD_W'(item_q.num_r), DV_W'({sr, 1'b0}), NB_LOAD};
        ret_d   = S_LD_Z;
        state_d = S_DIVW;
      end
      S_LD_Z: begin
        div_req = '{1'b1, DD_W'(item_q.num_z), DV_W'({sz, 1'b0}), NB_LOAD};
        ret_d   = S_LD_ST;
        state_d = S_DIVW;
      end
      S_LD_ST: state_d = S_LD_WR;
      S_LD_WR: begin
        mem_we  = ok_q;
        state_d = S_OUT;
      end
      S_SQX: begin
        mul_a   = MUL_W'(item_q.pos_x);
        mul_b   = MUL_W'(item_q.pos_x);
        state_d = S_SQY;
      end
      S_SQY: begin
        mul_a   = MUL_W'(item_q.pos_y);
        mul_b   = MUL_W'(item_q.pos_y);
        state_d = S_SQA;
      end
      S_SQA: state_d = S_SQRT;
      S_SQRT: begin
        if (bit_q[0]) state_d = S_QR;
      end
      S_QR: begin
        div_req = '{1'b1,
                    DD_W'($signed({1'b0, res_q[RAD_W-1:0]})) - DD_W'(cfg_i.radial_start),
                    DV_W'(sr), NB_CELL};
        ret_d   = S_QZ;
        state_d = S_DIVW;
      end
      S_QZ: begin
        div_req = '{1'b1, DD_W'(item_q.num_z), DV_W'(sz), NB_CELL};
        ret_d   = S_QCHK;
        state_d = S_DIVW;
      end
      S_QCHK: state_d = (ix_ok_q && iz_in) ? S_CW : S_OUT;
      S_CW: begin
        mul_a   = MUL_W'(wr);
        mul_b   = MUL_W'(wz);
        state_d = S_CR;
      end
      S_CR: begin
        mul_a   = MUL_W'($signed(rdata_q[2*FLD_W-1:FLD_W]));
        mul_b   = MUL_W'(prod_q[WGT_W-1:0]);
        state_d = S_CZ;
      end
      S_CZ: begin
        mul_a   = MUL_W'($signed(rdata_q[FLD_W-1:0]));
        mul_b   = MUL_W'(weight_q);
        state_d = S_CA;
      end
      S_CA: state_d = (k_q == 2'd3) ? S_NM : S_CW;
      S_NM: begin
        mul_a   = MUL_W'(sr);
        mul_b   = MUL_W'(sz);
        state_d = S_FZ;
      end
      S_FZ: begin
        div_req = '{1'b1, neg20(acc_z_q) + DD_W'(prod_q[WGT_W-1:0]),
                    DV_W'({prod_q[WGT_W-1:0], 1'b0}), NB_NORM};
        ret_d   = S_FR;
        state_d = S_DIVW;
      end
      S_FR: begin
        div_req = '{1'b1, neg20(acc_r_q) + DD_W'(den_q), DV_W'({den_q, 1'b0}), NB_NORM};
        ret_d   = S_BR;
        state_d = S_DIVW;
      end
      S_BR: begin
        if (r_q == '0) begin
          state_d = S_OUT;
        end else begin
          mul_a   = MUL_W'(quot_o);
          mul_b   = MUL_W'(item_q.pos_x);
          state_d = S_DX;
        end
      end
      S_DX, S_DY: begin
        div_req = '{1'b1, (DD_W'(prod_q) <<< 1) + DD_W'($signed({1'b0, r_q})),
                    DV_W'({r_q, 1'b0}), NB_ROT};
        ret_d   = (state_q == S_DX) ? S_FX : S_FY;
        state_d = S_DIVW;
      end
      S_FX: begin
        mul_a   = MUL_W'(br_q);
        mul_b   = MUL_W'(item_q.pos_y);
        state_d = S_DY;
      end
      S_FY: state_d = S_OUT;
      S_DIVW: begin
        if (div_rsp.done) state_d = ret_q;
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_full[PROD_W-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          item_q  <= head_i;
          k_q     <= '0;
          acc_r_q <= '0;
          acc_z_q <= '0;
        end
      end
      S_SQY: sq_q <= prod_q[SQ_W-1:0];
      S_SQA: begin
        sq_q  <= sq_q + prod_q[SQ_W-1:0];
        res_q <= '0;
        bit_q <= SQ_W'(1) << (SQ_W - 2);
      end
      S_SQRT: begin
        if (sq_ge) begin
          sq_q  <= sq_q - sq_sum;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      S_QR: r_q <= res_q[RAD_W-1:0];
      S_LD_Z, S_QZ: begin
        ix_q    <= div_rsp.quot[IX_W-1:0];
        ix_ok_q <= ix_in;
        rr_q    <= div_rsp.rem[STEP_W-1:0];
      end
      S_LD_ST: begin
        iz_q     <= div_rsp.quot[IZ_W-1:0];
        ok_q     <= ix_ok_q && iz_in;
        status_q <= (ix_ok_q && iz_in) ? ST_STORED : ST_BAD_INDEX;
        fx_q     <= '0;
        fy_q     <= '0;
        fz_q     <= '0;
      end
      S_QCHK: begin
        iz_q <= div_rsp.quot[IZ_W-1:0];
        rz_q <= div_rsp.rem[STEP_W-1:0];
        if (!(ix_ok_q && iz_in)) begin
          status_q <= ST_OUTSIDE;
          fx_q     <= '0;
          fy_q     <= '0;
          fz_q     <= '0;
        end
      end
      S_CR: weight_q <= prod_q[WGT_W-1:0];
      S_CZ: acc_r_q <= acc_r_q + prod_q;
      S_CA: begin
        acc_z_q <= acc_z_q + prod_q;
        k_q     <= k_q + 2'd1;
      end
      S_FZ: den_q <= prod_q[WGT_W-1:0];
      S_FR: fz_q <= quot_o;
      S_BR: begin
        br_q     <= quot_o;
        status_q <= ST_INSIDE;
        if (r_q == '0) begin
          fx_q <= quot_o;
          fy_q <= '0;
        end
      end
      S_FX: fx_q <= quot_o;
      S_FY: fy_q <= quot_o;
      default: ;
    endcase
  end

  // Both tables share one word per grid point: radial field high, axial low.
  always_ff @(posedge clk_i) begin
    if (mem_we) field_mem_q[mem_addr] <= {item_q.field_r, item_q.field_z};
    rdata_q <= field_mem_q[mem_addr];
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= OUT_DATA_W'({fz_q, fy_q, fx_q});
      m_user_q <= status_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_div_wait_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIVW |-> div_rsp.busy || div_rsp.done)
    else $error("waiting on an idle divider");

  a_load_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && (status_q == ST_STORED || status_q == ST_BAD_INDEX)
    |-> item_q.cmd == CMD_LOAD)
    else $error("load status on a query");

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && status_q == ST_OUTSIDE |-> fx_q == '0 && fy_q == '0 && fz_q == '0)
    else $error("nonzero field outside the map");

endmodule

FILE: hdl/axial_field_map_bilinear_lookup_core.sv
// Cylindrical field map with bilinear lookup. Load transfers (tuser 0) store
// one grid point's radial and axial field at the nearest (r, z) cell; query
// transfers (tuser 1) return the interpolated field at (x, y, z) rotated onto
// x and y and scaled by -10, or zeros with an outside status. Every input
// transfer produces exactly one output transfer, in order. Items go through a
// two-entry queue into a sequencer that handles one item at a time; its pace
// is set by the shared divider, which retires one quotient bit per cycle. A
// load makes two 28-bit cell divisions; a query makes two 27-bit cell
// divisions, a 24-step square root, four corner reads with three multiplies
// each, two 61-bit normalizing divisions and, off the axis, two 54-bit
// rotation divisions. The map memory is not
// initialized; only points that were loaded may be queried. Configuration
// writes are taken at any time but must only be issued while the block is idle.
module axial_field_map_bilinear_lookup_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [afm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [afm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // pos_x, pos_y, pos_z, load_field_r, load_field_z
  input  logic [afm_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // command
  input  logic [0:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // field_x, field_y, field_z, zero fill to a whole byte
  output logic [afm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // status
  output logic [1:0]                          m_axis_tuser
);
  import afm_pkg::*;

  cfg_t  cfg_q;
  item_t push_item, head;
  logic  push, pop, fifo_empty, fifo_full;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radial_step  <= STEP_W'(128);
      cfg_q.radial_start <= '0;
      cfg_q.axial_step   <= STEP_W'(128);
      cfg_q.axial_start  <= POS_W'(286963);
      cfg_q.axial_center <= POS_W'(320000);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RADIAL_STEP:  cfg_q.radial_step  <= cfg_data_i[STEP_W-1:0];
        REG_RADIAL_START: cfg_q.radial_start <= $signed(cfg_data_i[POS_W-1:0]);
        REG_AXIAL_STEP:   cfg_q.axial_step   <= cfg_data_i[STEP_W-1:0];
        REG_AXIAL_START:  cfg_q.axial_start  <= $signed(cfg_data_i[POS_W-1:0]);
        REG_AXIAL_CENTER: cfg_q.axial_center <= $signed(cfg_data_i[POS_W-1:0]);
        default: ;
      endcase
    end
  end

  // The front classifies each transfer and prepares its cell dividends.
  afm_front u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .cfg_i        (cfg_q),
    .fifo_full_i  (fifo_full),
    .push_o       (push),
    .item_o       (push_item)
  );

  afm_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(push_item),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (fifo_empty),
    .full_o     (fifo_full)
  );

  // The back end owns the map memory, the multiplier and the divider.
  afm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (head),
    .empty_i      (fifo_empty),
    .pop_o        (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule
